// ----- hdl/ift_pkg.sv -----
// ift_pkg: types, verdict codes and constants of the IPv4 fragment context tracker.
// No dependencies; used by every module of the block.
package ift_pkg;

  localparam int SLOTS_DEFAULT = 32;

  localparam logic [15:0] TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] MIN_CAPTURE   = 16'd20;
  localparam logic [3:0]  IP_VERSION4   = 4'd4;
  localparam logic [3:0]  MAX_HDR_WORDS = 4'd8;
  localparam logic [7:0]  TCP_PROTO     = 8'd6;
  localparam logic [7:0]  UDP_PROTO     = 8'd17;
  localparam int          OFS_BITS      = 13;  // fragment offset field width
  localparam int          OFS_SHIFT     = 3;   // offset unit is 8 bytes
  localparam int          MF_POS        = 13;  // more-fragments flag

  localparam logic [3:0] VERD_WHOLE     = 4'd0;
  localparam logic [3:0] VERD_STORED    = 4'd1;
  localparam logic [3:0] VERD_REASM     = 4'd2;
  localparam logic [3:0] VERD_BAD_VER   = 4'd3;
  localparam logic [3:0] VERD_HDR_LONG  = 4'd4;
  localparam logic [3:0] VERD_LEN_SHORT = 4'd5;
  localparam logic [3:0] VERD_PROTO     = 4'd6;
  localparam logic [3:0] VERD_TRUNC     = 4'd7;
  localparam logic [3:0] VERD_FULL      = 4'd8;
  localparam logic [3:0] VERD_TICK      = 4'd9;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [15:0] frag_field;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] captured_length;
    logic [7:0]  elapsed;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic        deliver_udp;
    logic [4:0]  slot;
    logic [5:0]  payload_offset;
    logic [15:0] pay_len;
    logic [15:0] frag_byte_offset;
    logic [31:0] expired_mask;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] ident;
  } key_t;

  // header check summary
  typedef struct packed {
    logic        drop;
    logic [3:0]  drop_code;
    logic        udp;
    logic [5:0]  pofs;
    logic [15:0] psize;
    logic [15:0] fofs;
    logic        is_frag;
    logic        more;
  } chk_t;

  // shared compare unit results
  typedef struct packed {
    logic        key_eq;
    logic        expired;
    logic [15:0] tmr_dec;
  } cmp_t;

endpackage

// ----- hdl/ift_hdr_check.sv -----
// ift_hdr_check: field checks and length arithmetic on one parsed IPv4 header.
// Depends on ift_pkg.
module ift_hdr_check (
  input  ift_pkg::in_item_t item,
  output ift_pkg::chk_t     chk
);

  logic [5:0] pofs;

  assign pofs = {item.header_words, 2'b00};

  always_comb begin
    chk.drop      = 1'b1;
    chk.drop_code = ift_pkg::VERD_PROTO;
    priority if (item.captured_length <= ift_pkg::MIN_CAPTURE) begin
      chk.drop_code = ift_pkg::VERD_TRUNC;
    end else if (item.version != ift_pkg::IP_VERSION4) begin
      chk.drop_code = ift_pkg::VERD_BAD_VER;
    end else if (item.header_words > ift_pkg::MAX_HDR_WORDS) begin
      chk.drop_code = ift_pkg::VERD_HDR_LONG;
    end else if (item.total_length < 16'(pofs)) begin
      chk.drop_code = ift_pkg::VERD_LEN_SHORT;
    end else if (item.protocol == ift_pkg::TCP_PROTO ||
                 item.protocol == ift_pkg::UDP_PROTO) begin
      chk.drop = 1'b0;
    end else begin
      chk.drop_code = ift_pkg::VERD_PROTO;
    end
    chk.udp     = (item.protocol == ift_pkg::UDP_PROTO);
    chk.pofs    = pofs;
    chk.psize   = item.total_length - 16'(pofs);
    chk.fofs    = 16'({item.frag_field[ift_pkg::OFS_BITS-1:0], ift_pkg::OFS_SHIFT'(0)});
    chk.is_frag = (item.frag_field != 16'd0);
    chk.more    = item.frag_field[ift_pkg::MF_POS];
  end

endmodule

// ----- hdl/ift_cmp_unit.sv -----
// ift_cmp_unit: shared compare unit used by every scan step (key match, timer aging).
// Depends on ift_pkg.
module ift_cmp_unit (
  input  ift_pkg::key_t  key_a,
  input  ift_pkg::key_t  key_b,
  input  logic [15:0]    tmr,
  input  logic [7:0]     elapsed,
  output ift_pkg::cmp_t  res
);

  logic [16:0] diff;

  assign diff = {1'b0, tmr} - {9'd0, elapsed};

  always_comb begin
    res.key_eq  = (key_a == key_b);
    // timer <= elapsed: borrow out or exact zero
    res.expired = diff[16] | (diff[15:0] == 16'd0);
    res.tmr_dec = diff[15:0];
  end

endmodule

// ----- hdl/ift_slot_mem.sv -----
// ift_slot_mem: per-slot key and timer memories, one write port each, registered read.
// Depends on ift_pkg.
module ift_slot_mem #(
  parameter int SLOTS = ift_pkg::SLOTS_DEFAULT,
  parameter int IDX_W = 5
) (
  input  logic              clk,
  input  logic              key_we,
  input  logic [IDX_W-1:0]  key_waddr,
  input  ift_pkg::key_t     key_wdata,
  input  logic              tmr_we,
  input  logic [IDX_W-1:0]  tmr_waddr,
  input  logic [15:0]       tmr_wdata,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output ift_pkg::key_t     key_q,
  output logic [15:0]       tmr_q
);

  ift_pkg::key_t key_mem [SLOTS];
  logic [15:0]   tmr_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (rd_en) begin
      key_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tmr_we) begin
      tmr_mem[tmr_waddr] <= tmr_wdata;
    end
    if (rd_en) begin
      tmr_q <= tmr_mem[rd_addr];
    end
  end

endmodule

// ----- hdl/ipv4_fragment_context_tracker_unit.sv -----
// ipv4_fragment_context_tracker_unit: top level, sequencer over the slot table.
// Depends on ift_pkg, ift_hdr_check, ift_cmp_unit, ift_slot_mem.
//
// channel  | ports                      | handshake
// ---------+----------------------------+----------------------------------
// input    | start, busy, in_item       | beat taken when start && !busy
// result   | out_strobe, out_item       | one-cycle strobe, cannot stall
// config   | cfg_we, cfg_wdata          | written when cfg_we is high
//
// Dropped or whole headers: decided in ST_EVAL, strobe registered on the return to ST_IDLE.
// Fragments: a linear key scan, one slot per cycle through the memory read port,
// ending at the first match or at the last slot. Ticks age every slot.
// busy is high from accept until the cycle of the strobe; reset clears the
// live bits at once, so no clearing pass is needed.
module ipv4_fragment_context_tracker_unit #(
  parameter int SLOTS = ift_pkg::SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ift_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output ift_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_SRCH = 4'b0100,
    ST_AGE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  ift_pkg::in_item_t   item_r;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic                iss_done_r, iss_done_nxt;
  logic [IDX_W-1:0]    proc_idx_r, proc_idx_nxt;
  logic                proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic                free_vld_r, free_vld_nxt;
  logic [31:0]         mask_r, mask_nxt;
  logic [SLOTS-1:0]    live_r, live_nxt;
  logic [15:0]         timeout_r;
  logic                out_strobe_r, out_strobe_nxt;
  ift_pkg::out_item_t  out_item_r, out_item_nxt;

  ift_pkg::chk_t       chk;
  ift_pkg::cmp_t       cmp;
  ift_pkg::key_t       item_key;
  ift_pkg::key_t       key_q;
  logic [15:0]         tmr_q;
  logic                rd_en;
  logic                key_we;
  logic                tmr_we;
  logic [IDX_W-1:0]    wr_idx;
  logic [15:0]         tmr_wdata;
  logic                live_here;
  logic [IDX_W-1:0]    hit_idx;

  assign item_key = '{src: item_r.src_ip, dst: item_r.dst_ip, ident: item_r.ident};

  ift_hdr_check u_hdr (
    .item (item_r),
    .chk  (chk)
  );

  ift_cmp_unit u_cmp (
    .key_a   (key_q),
    .key_b   (item_key),
    .tmr     (tmr_q),
    .elapsed (item_r.elapsed),
    .res     (cmp)
  );

  ift_slot_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk       (clk),
    .key_we    (key_we),
    .key_waddr (wr_idx),
    .key_wdata (item_key),
    .tmr_we    (tmr_we),
    .tmr_waddr (wr_idx),
    .tmr_wdata (tmr_wdata),
    .rd_en     (rd_en),
    .rd_addr   (addr_r),
    .key_q     (key_q),
    .tmr_q     (tmr_q)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;
  assign rd_en      = (state_r == ST_SRCH || state_r == ST_AGE) && !iss_done_r;
  assign live_here  = live_r[proc_idx_r];

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    iss_done_nxt   = iss_done_r;
    proc_idx_nxt   = proc_idx_r;
    proc_vld_nxt   = 1'b0;
    free_idx_nxt   = free_idx_r;
    free_vld_nxt   = free_vld_r;
    mask_nxt       = mask_r;
    live_nxt       = live_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    key_we         = 1'b0;
    tmr_we         = 1'b0;
    wr_idx         = proc_idx_r;
    tmr_wdata      = cmp.tmr_dec;
    hit_idx        = proc_idx_r;

    // read issue stage of the scan
    if (rd_en) begin
      proc_idx_nxt = addr_r;
      proc_vld_nxt = 1'b1;
      if (addr_r == LAST) begin
        iss_done_nxt = 1'b1;
      end else begin
        addr_nxt = addr_r + IDX_W'(1);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        addr_nxt     = '0;
        iss_done_nxt = 1'b0;
        free_vld_nxt = 1'b0;
        mask_nxt     = '0;
        out_item_nxt = '0;
        if (item_r.op == ift_pkg::OP_TICK) begin
          state_nxt = ST_AGE;
        end else if (chk.drop) begin
          out_item_nxt.verdict = chk.drop_code;
          out_strobe_nxt       = 1'b1;
          state_nxt            = ST_IDLE;
        end else if (!chk.is_frag) begin
          out_item_nxt.verdict          = ift_pkg::VERD_WHOLE;
          out_item_nxt.deliver_udp      = chk.udp;
          out_item_nxt.payload_offset   = chk.pofs;
          out_item_nxt.pay_len          = chk.psize;
          out_item_nxt.frag_byte_offset = chk.fofs;
          out_strobe_nxt                = 1'b1;
          state_nxt                     = ST_IDLE;
        end else begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (proc_vld_r) begin
          if (!free_vld_r && !live_here) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = proc_idx_r;
          end
          if ((live_here && cmp.key_eq) || proc_idx_r == LAST) begin
            out_item_nxt                  = '0;
            out_item_nxt.deliver_udp      = chk.udp;
            out_item_nxt.payload_offset   = chk.pofs;
            out_item_nxt.pay_len          = chk.psize;
            out_item_nxt.frag_byte_offset = chk.fofs;
            out_strobe_nxt                = 1'b1;
            state_nxt                     = ST_IDLE;
            if (live_here && cmp.key_eq) begin
              hit_idx = proc_idx_r;
            end else begin
              // no match anywhere: take the lowest free slot
              hit_idx   = free_vld_r ? free_idx_r : proc_idx_r;
              wr_idx    = hit_idx;
              key_we    = free_vld_r || !live_here;
              tmr_we    = key_we;
              tmr_wdata = timeout_r;
            end
            if (!(live_here && cmp.key_eq) && free_vld_r == 1'b0 && live_here) begin
              out_item_nxt = '0;
              out_item_nxt.verdict = ift_pkg::VERD_FULL;
            end else begin
              out_item_nxt.slot    = 5'(hit_idx);
              out_item_nxt.verdict = chk.more ? ift_pkg::VERD_STORED : ift_pkg::VERD_REASM;
              live_nxt[hit_idx]    = chk.more;
            end
          end
        end
      end
      ST_AGE: begin
        if (proc_vld_r) begin
          if (live_here) begin
            if (cmp.expired) begin
              live_nxt[proc_idx_r] = 1'b0;
              mask_nxt = mask_r | (32'd1 << proc_idx_r);
            end else begin
              tmr_we = 1'b1;
            end
          end
          if (proc_idx_r == LAST) begin
            out_item_nxt              = '0;
            out_item_nxt.verdict      = ift_pkg::VERD_TICK;
            out_item_nxt.expired_mask = mask_nxt;
            out_strobe_nxt            = 1'b1;
            state_nxt                 = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      addr_r       <= '0;
      iss_done_r   <= 1'b0;
      proc_idx_r   <= '0;
      proc_vld_r   <= 1'b0;
      free_idx_r   <= '0;
      free_vld_r   <= 1'b0;
      mask_r       <= '0;
      live_r       <= '0;
      timeout_r    <= ift_pkg::TIMEOUT_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      iss_done_r   <= iss_done_nxt;
      proc_idx_r   <= proc_idx_nxt;
      proc_vld_r   <= proc_vld_nxt;
      free_idx_r   <= free_idx_nxt;
      free_vld_r   <= free_vld_nxt;
      mask_r       <= mask_nxt;
      live_r       <= live_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- hdl/ift_checker.sv -----
// ift_checker: port-level checks of the fragment context tracker, bound to the top level.
// Depends on ift_pkg and ipv4_fragment_context_tracker_unit.
module ift_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input ift_pkg::out_item_t out_item
);

  // every beat passes through ST_EVAL before its strobe, so strobes never touch
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held two cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.verdict == ift_pkg::VERD_TICK) |->
      (out_item.slot == 5'd0 && out_item.pay_len == 16'd0 &&
       out_item.deliver_udp == 1'b0))
    else $error("tick result carries header fields");

  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.verdict == ift_pkg::VERD_BAD_VER ||
                    out_item.verdict == ift_pkg::VERD_TRUNC ||
                    out_item.verdict == ift_pkg::VERD_FULL)) |->
      (out_item.expired_mask == 32'd0 && out_item.slot == 5'd0 &&
       out_item.pay_len == 16'd0))
    else $error("dropped header carries nonzero fields");

endmodule

bind ipv4_fragment_context_tracker_unit ift_checker u_ift_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// ----- verif/ipv4_fragment_context_tracker_unit_tb.sv -----
// Self-checking testbench for ipv4_fragment_context_tracker_unit: header checks,
// fragment slot allocation/match/free, aging ticks and timeout register changes.
// Depends on ift_pkg and the RTL of the block only.
module ipv4_fragment_context_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ift_pkg::*;

  localparam int NSLOT       = SLOTS_DEFAULT;
  localparam int NKEY        = 48;
  localparam int PHASE_BEATS = 280;
  localparam int SETTLE      = NSLOT + 8;
  localparam int STALL_LIMIT = 2000;

  class reassembly_scoreboard;
    bit        slot_used [NSLOT];
    bit [31:0] slot_src  [NSLOT];
    bit [31:0] slot_dst  [NSLOT];
    bit [15:0] slot_id   [NSLOT];
    bit [15:0] slot_age  [NSLOT];
    bit [15:0] timeout;
    out_item_t verdict_q [$];
    int        mismatches;
    int        seen [16];
    int        aged_out;

    function new();
      timeout = TIMEOUT_RESET;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function out_item_t next_verdict(in_item_t it);
      out_item_t r;
      int        hit;
      bit [5:0]  pofs;
      r = '0;
      if (it.op == OP_TICK) begin
        r.verdict = VERD_TICK;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_used[i]) begin
            if (slot_age[i] <= {8'd0, it.elapsed}) begin
              slot_used[i] = 1'b0;
              if (i < 32) r.expired_mask[i] = 1'b1;
            end else begin
              slot_age[i] = slot_age[i] - {8'd0, it.elapsed};
            end
          end
        end
        return r;
      end
      // drop checks, in priority order
      pofs = {it.header_words, 2'b00};
      if (it.captured_length <= MIN_CAPTURE) r.verdict = VERD_TRUNC;
      else if (it.version != IP_VERSION4) r.verdict = VERD_BAD_VER;
      else if (it.header_words > MAX_HDR_WORDS) r.verdict = VERD_HDR_LONG;
      else if (it.total_length < {10'd0, pofs}) r.verdict = VERD_LEN_SHORT;
      else if (it.protocol != TCP_PROTO && it.protocol != UDP_PROTO) r.verdict = VERD_PROTO;
      else begin
        r.verdict          = VERD_WHOLE;
        r.deliver_udp      = (it.protocol == UDP_PROTO);
        r.payload_offset   = pofs;
        r.pay_len          = it.total_length - {10'd0, pofs};
        r.frag_byte_offset = {it.frag_field[OFS_BITS-1:0], 3'b000};
      end
      if (r.verdict != VERD_WHOLE || it.frag_field == 16'd0) return r;

      hit = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (hit < 0 && slot_used[i] && slot_src[i] == it.src_ip &&
            slot_dst[i] == it.dst_ip && slot_id[i] == it.ident) hit = i;
      end
      if (hit < 0) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (hit < 0 && !slot_used[i]) hit = i;
        end
        if (hit < 0) begin
          r = '0;
          r.verdict = VERD_FULL;
          return r;
        end
        slot_used[hit] = 1'b1;
        slot_src[hit]  = it.src_ip;
        slot_dst[hit]  = it.dst_ip;
        slot_id[hit]   = it.ident;
        slot_age[hit]  = timeout;
      end
      r.slot = hit[4:0];
      if (it.frag_field[MF_POS]) begin
        r.verdict = VERD_STORED;
      end else begin
        r.verdict = VERD_REASM;
        slot_used[hit] = 1'b0;
      end
      return r;
    endfunction

    function void note_beat(in_item_t it);
      verdict_q.insert(verdict_q.size(), next_verdict(it));
    endfunction

    function void cmp_field(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual verdict %0d",
                 $time, got.verdict);
        mismatches++;
        return;
      end
      exp = verdict_q.pop_front();
      cmp_field("verdict", exp.verdict, got.verdict);
      cmp_field("deliver_udp", exp.deliver_udp, got.deliver_udp);
      cmp_field("slot", exp.slot, got.slot);
      cmp_field("payload_offset", exp.payload_offset, got.payload_offset);
      cmp_field("pay_len", exp.pay_len, got.pay_len);
      cmp_field("frag_byte_offset", exp.frag_byte_offset, got.frag_byte_offset);
      cmp_field("expired_mask", exp.expired_mask, got.expired_mask);
      seen[exp.verdict]++;
      aged_out += $countones(exp.expired_mask);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  reassembly_scoreboard sb = new();

  logic [31:0] key_src [NKEY];
  logic [31:0] key_dst [NKEY];
  logic [15:0] key_id  [NKEY];
  bit          no_idle;
  int          stall_cycles;

  ipv4_fragment_context_tracker_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("** ipv4_fragment_context_tracker_unit: FAILED **");
      $finish;
    end
  end

  // random idle gap, then hold start until the block takes the beat
  task automatic send_beat(input in_item_t it);
    while (!no_idle && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(it);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    sb.timeout = value;
  endtask

  function automatic in_item_t hdr(logic [3:0] ver, logic [3:0] hw, logic [15:0] total,
                                   logic [15:0] frag, logic [7:0] proto,
                                   logic [15:0] cap, int k);
    in_item_t it;
    it                 = '0;
    it.op              = OP_HEADER;
    it.version         = ver;
    it.header_words    = hw;
    it.total_length    = total;
    it.frag_field      = frag;
    it.protocol        = proto;
    it.captured_length = cap;
    it.src_ip          = key_src[k];
    it.dst_ip          = key_dst[k];
    it.ident           = key_id[k];
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [7:0] el);
    in_item_t it;
    it         = '0;
    it.op      = OP_TICK;
    it.elapsed = el;
    return it;
  endfunction

  function automatic in_item_t make_item();
    logic [159:0] raw;
    in_item_t     it;
    int           pick;
    int           k;
    int           pofs;
    raw  = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it   = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 5) return it;  // pure noise, either op
    if (pick < 17) begin
      it.op = OP_TICK;
      case ($urandom_range(4))
        0:       it.elapsed = 8'd0;
        1, 2:    it.elapsed = 8'($urandom_range(15));
        default: it.elapsed = 8'($urandom_range(255));
      endcase
      return it;
    end
    it.op           = OP_HEADER;
    it.version      = IP_VERSION4;
    it.header_words = ($urandom_range(9) == 0) ? 4'($urandom_range(4)) : 4'($urandom_range(5, 8));
    pofs            = it.header_words * 4;
    it.total_length = ($urandom_range(9) == 0) ? 16'($urandom_range(pofs, 65535))
                                               : 16'(pofs + $urandom_range(1500));
    it.captured_length = 16'($urandom_range(21, 65535));
    it.protocol        = $urandom_range(1) ? UDP_PROTO : TCP_PROTO;
    if ($urandom_range(19) != 0) begin
      k         = $urandom_range(NKEY - 1);
      it.src_ip = key_src[k];
      it.dst_ip = key_dst[k];
      it.ident  = key_id[k];
    end
    case ($urandom_range(9))
      0, 1:          it.frag_field = 16'd0;
      2, 3, 4, 5, 6: it.frag_field[MF_POS] = 1'b1;
      default: begin
        it.frag_field[MF_POS] = 1'b0;
        if (it.frag_field == 16'd0) it.frag_field = 16'd1;
      end
    endcase
    // a share of otherwise good headers fails exactly one check
    if (pick < 27) begin
      case ($urandom_range(4))
        0: it.captured_length = 16'($urandom_range(20));
        1: it.version = IP_VERSION4 ^ 4'($urandom_range(1, 15));
        2: it.header_words = 4'($urandom_range(9, 15));
        3: begin
          it.header_words = 4'($urandom_range(1, 8));
          it.total_length = 16'($urandom_range(it.header_words * 4 - 1));
        end
        default: begin
          it.protocol = 8'($urandom);
          if (it.protocol == TCP_PROTO || it.protocol == UDP_PROTO) it.protocol = 8'hFF;
        end
      endcase
    end
    return it;
  endfunction

  initial begin
    logic [15:0] phase_tmo [6];
    int          headers;

    // keys often differ from a neighbor in one field only
    for (int k = 0; k < NKEY; k++) begin
      if (k % 4 == 0) begin
        key_src[k] = $urandom;
        key_dst[k] = $urandom;
        key_id[k]  = 16'($urandom);
      end else begin
        key_src[k] = key_src[k-1];
        key_dst[k] = key_dst[k-1];
        key_id[k]  = key_id[k-1];
        case (k % 3)
          0:       key_src[k][$urandom_range(31)] = ~key_src[k-1][0];
          1:       key_dst[k] = key_dst[k-1] ^ (32'd1 << $urandom_range(31));
          default: key_id[k]  = key_id[k-1] ^ (16'd1 << $urandom_range(15));
        endcase
        if (key_src[k] == key_src[k-1] && key_dst[k] == key_dst[k-1] &&
            key_id[k] == key_id[k-1]) key_id[k] = ~key_id[k];
      end
    end
    key_src[0] = '0;
    key_dst[0] = '0;
    key_id[0]  = '0;
    key_src[5] = '1;
    key_dst[5] = '1;
    key_id[5]  = '1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_beat(tick_item(8'd0));
    send_beat(hdr(4'd4, 4'd5, 16'd100, 16'h0000, TCP_PROTO, 16'd20, 0));
    send_beat(hdr(4'd4, 4'd5, 16'd100, 16'h0000, UDP_PROTO, 16'd21, 0));
    send_beat(hdr(4'd4, 4'd5, 16'd100, 16'h0000, TCP_PROTO, 16'd0, 0));
    send_beat(hdr(4'd6, 4'd5, 16'd100, 16'h0000, TCP_PROTO, 16'hFFFF, 0));
    send_beat(hdr(4'd4, 4'd9, 16'd100, 16'h0000, TCP_PROTO, 16'd100, 0));
    send_beat(hdr(4'd4, 4'd15, 16'd100, 16'h0000, UDP_PROTO, 16'd100, 0));
    send_beat(hdr(4'd4, 4'd8, 16'd31, 16'h0000, TCP_PROTO, 16'd100, 0));
    send_beat(hdr(4'd4, 4'd8, 16'd32, 16'h0000, UDP_PROTO, 16'd100, 0));
    send_beat(hdr(4'd4, 4'd5, 16'd100, 16'h0000, 8'd1, 16'd100, 0));
    send_beat(hdr(4'd4, 4'd0, 16'd0, 16'h0000, TCP_PROTO, 16'd100, 0));  // IHL below 5
    send_beat(hdr(4'd4, 4'd5, 16'd1500, 16'h2000, TCP_PROTO, 16'd1500, 1));
    send_beat(hdr(4'd4, 4'd5, 16'd1500, 16'h3FFF, UDP_PROTO, 16'd1500, 1));
    send_beat(hdr(4'd4, 4'd5, 16'd1500, 16'h2000, TCP_PROTO, 16'd1500, 2));
    send_beat(hdr(4'd4, 4'd5, 16'd600, 16'h00B9, TCP_PROTO, 16'd600, 1));
    send_beat(hdr(4'd4, 4'd5, 16'd600, 16'h0005, TCP_PROTO, 16'd600, 3));  // last fragment, first seen for its key
    send_beat(hdr(4'd4, 4'd5, 16'd600, 16'h4000, TCP_PROTO, 16'd600, 4));  // DF only
    send_beat(hdr(4'd4, 4'd8, 16'hFFFF, 16'hFFFF, UDP_PROTO, 16'hFFFF, 5));
    send_beat(tick_item(8'd0));
    send_beat(tick_item(8'hFF));
    set_timeout(16'd0);
    send_beat(hdr(4'd4, 4'd5, 16'd400, 16'h2010, TCP_PROTO, 16'd400, 6));
    send_beat(tick_item(8'd0));  // zero timer expires on zero elapsed

    // random phases, one timeout setting each
    phase_tmo[0] = 16'd1;
    phase_tmo[1] = 16'hFFFF;
    phase_tmo[2] = TIMEOUT_RESET;
    phase_tmo[3] = 16'd0;
    phase_tmo[4] = 16'($urandom_range(2, 400));
    phase_tmo[5] = 16'd40;
    for (int p = 0; p < 6; p++) begin
      set_timeout(phase_tmo[p]);
      no_idle = (p == 2);
      repeat (PHASE_BEATS) send_beat(make_item());
    end
    no_idle = 1'b0;
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    headers = 0;
    for (int v = 0; v < 9; v++) headers += sb.seen[v];
    $display("run: %0d headers, %0d ticks over six timeout settings from 0 to 65535",
             headers, sb.seen[VERD_TICK]);
    $display("run: %0d whole, %0d stored, %0d reassembled, %0d table full, %0d aged out",
             sb.seen[VERD_WHOLE], sb.seen[VERD_STORED], sb.seen[VERD_REASM],
             sb.seen[VERD_FULL], sb.aged_out);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** ipv4_fragment_context_tracker_unit: PASSED **");
    end else begin
      $display("** ipv4_fragment_context_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule
